// ===== sv/dtt_pkg.sv =====
// Package: shared types, token kind codes and helper functions for the text tokenizer.
`timescale 1ns / 1ps

package dtt_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int LEN_W           = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int PTR_W           = $clog2(QUEUE_DEPTH);
  localparam int CNT_W           = $clog2(QUEUE_DEPTH + 1);

  localparam logic [4:0] K_LBRACE = 5'd0;
  localparam logic [4:0] K_RBRACE = 5'd1;
  localparam logic [4:0] K_LBRACK = 5'd2;
  localparam logic [4:0] K_RBRACK = 5'd3;
  localparam logic [4:0] K_EQUAL  = 5'd4;
  localparam logic [4:0] K_COMMA  = 5'd5;
  localparam logic [4:0] K_POS    = 5'd6;
  localparam logic [4:0] K_NEG    = 5'd7;
  localparam logic [4:0] K_DOT    = 5'd8;
  localparam logic [4:0] K_AT     = 5'd9;
  localparam logic [4:0] K_DOLLAR = 5'd10;
  localparam logic [4:0] K_BINARY = 5'd11;
  localparam logic [4:0] K_STRING = 5'd12;
  localparam logic [4:0] K_SYMBOL = 5'd13;
  localparam logic [4:0] K_ID     = 5'd14;
  localparam logic [4:0] K_FLOAT  = 5'd15;
  localparam logic [4:0] K_INT    = 5'd16;
  localparam logic [4:0] K_TRUE   = 5'd17;
  localparam logic [4:0] K_FALSE  = 5'd18;
  localparam logic [4:0] K_NULL   = 5'd19;
  localparam logic [4:0] K_EOS    = 5'd20;
  localparam logic [4:0] K_ERR    = 5'd21;

  typedef enum logic [9:0] {
    M_IDLE      = 10'b00_0000_0001,
    M_SIGN      = 10'b00_0000_0010,
    M_DOT       = 10'b00_0000_0100,
    M_NUMBER    = 10'b00_0000_1000,
    M_ALPHA     = 10'b00_0001_0000,
    M_SYM_START = 10'b00_0010_0000,
    M_SYM_ALPHA = 10'b00_0100_0000,
    M_Q_STRING  = 10'b00_1000_0000,
    M_Q_BINARY  = 10'b01_0000_0000,
    M_Q_SYMBOL  = 10'b10_0000_0000
  } mode_t;

  typedef struct packed {
    logic [4:0]       kind;
    logic [15:0]      offset;
    logic [LEN_W-1:0] length;
    logic             last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v == '1) ? v : v + LEN_W'(1);
  endfunction

  // Drop keyword candidates whose character at position idx differs from c.
  function automatic logic [2:0] kw_update(input logic [2:0] f, input logic [LEN_W-1:0] idx,
                                           input logic [7:0] c);
    logic [2:0] r;
    r = f;
    if (!((idx == 0 && c == "t") || (idx == 1 && c == "r") ||
          (idx == 2 && c == "u") || (idx == 3 && c == "e")))
      r[0] = 1'b0;
    if (!((idx == 0 && c == "f") || (idx == 1 && c == "a") || (idx == 2 && c == "l") ||
          (idx == 3 && c == "s") || (idx == 4 && c == "e")))
      r[1] = 1'b0;
    if (!((idx == 0 && c == "n") || (idx == 1 && c == "u") ||
          (idx == 2 && c == "l") || (idx == 3 && c == "l")))
      r[2] = 1'b0;
    return r;
  endfunction

  function automatic logic [4:0] kw_kind(input logic [2:0] f, input logic [LEN_W-1:0] len);
    logic [4:0] k;
    k = K_ID;
    if (f[2] && len == 4) k = K_NULL;
    if (f[1] && len == 5) k = K_FALSE;
    if (f[0] && len == 4) k = K_TRUE;
    return k;
  endfunction

endpackage

// ===== sv/data_text_tokenizer.sv =====
// Top level: streaming text tokenizer with a small token queue on the output side.
`timescale 1ns / 1ps

// Takes one text byte per cycle (a zero byte ends the text and resets the offset)
// and emits tokens as kind, start offset and saturating length. The lexer state
// advances in the cycle a byte is accepted; each byte yields zero, one or two
// tokens, which go into a four-entry queue. The output side drains one token per
// cycle unless out_stall is high; a byte that closes one token and opens another
// queues two. The input stalls whenever fewer than two queue slots are free.
module data_text_tokenizer #(
  parameter int OFFSET_BITS = dtt_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  token_kind,
  output logic [15:0] token_offset,
  output logic [15:0] token_length,
  output logic        last_of_run
);

  dtt_pkg::mode_t           lex_mode, mode_next;
  logic                     escape_pending, esc_next;
  logic                     seen_dot, dot_next;
  logic                     seen_exponent, exp_next;
  logic                     after_exponent_letter, aft_next;
  logic [OFFSET_BITS-1:0]   start_offset, start_next;
  logic [OFFSET_BITS-1:0]   text_offset, offset_next;
  logic [dtt_pkg::LEN_W-1:0] run_length, run_next;
  logic [2:0]               keyword_match_flags, kw_next;
  logic [7:0]               held_byte, held_next;

  logic                     taken, num_step, q_step, after_exp;
  logic [4:0]               q_kind;
  logic                     p_emit, i_emit;
  logic [4:0]               p_kind, i_kind;
  logic [dtt_pkg::LEN_W-1:0] p_len, i_len;
  logic [7:0]               c;

  dtt_pkg::token_t          tok0, tok1;
  logic [1:0]               tok_cnt;

  dtt_pkg::token_t          queue [dtt_pkg::QUEUE_DEPTH];
  logic [dtt_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [dtt_pkg::CNT_W-1:0] count;
  logic                     in_fire, out_fire;

  assign in_stall  = count > dtt_pkg::CNT_W'(dtt_pkg::QUEUE_DEPTH - 2);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = count != '0;
  assign out_fire  = out_valid && !out_stall;

  always_comb begin
    mode_next   = lex_mode;
    esc_next    = escape_pending;
    dot_next    = seen_dot;
    exp_next    = seen_exponent;
    aft_next    = after_exponent_letter;
    start_next  = start_offset;
    run_next    = run_length;
    kw_next     = keyword_match_flags;
    held_next   = held_byte;
    offset_next = text_offset;
    c           = in_byte;
    taken       = 1'b0;
    num_step    = 1'b0;
    q_step      = 1'b0;
    q_kind      = dtt_pkg::K_STRING;
    after_exp   = 1'b0;
    p_emit      = 1'b0;
    p_kind      = dtt_pkg::K_ID;
    p_len       = run_length;
    i_emit      = 1'b0;
    i_kind      = dtt_pkg::K_ERR;
    i_len       = dtt_pkg::LEN_W'(1);

    // pending token sees the byte first
    case (lex_mode)
      dtt_pkg::M_IDLE: begin
      end
      dtt_pkg::M_SIGN: begin
        if (dtt_pkg::is_digit(c) || c == ".") begin
          mode_next = dtt_pkg::M_NUMBER;
          dot_next  = 1'b0;
          exp_next  = 1'b0;
          aft_next  = 1'b0;
          num_step  = 1'b1;
        end else begin
          p_emit    = 1'b1;
          p_kind    = (held_byte == "+") ? dtt_pkg::K_POS : dtt_pkg::K_NEG;
          mode_next = dtt_pkg::M_IDLE;
        end
      end
      dtt_pkg::M_DOT: begin
        if (dtt_pkg::is_digit(c)) begin
          mode_next = dtt_pkg::M_NUMBER;
          dot_next  = 1'b1;
          exp_next  = 1'b0;
          aft_next  = 1'b0;
          run_next  = dtt_pkg::sat_inc(run_length);
          taken     = 1'b1;
        end else begin
          p_emit    = 1'b1;
          p_kind    = dtt_pkg::K_DOT;
          mode_next = dtt_pkg::M_IDLE;
        end
      end
      dtt_pkg::M_NUMBER: num_step = 1'b1;
      dtt_pkg::M_ALPHA: begin
        if (run_length == dtt_pkg::LEN_W'(1) && held_byte == "b" && c == "\"") begin
          mode_next = dtt_pkg::M_Q_BINARY;
          esc_next  = 1'b0;
          run_next  = dtt_pkg::sat_inc(run_length);
          taken     = 1'b1;
        end else if (dtt_pkg::is_letter(c)) begin
          kw_next  = dtt_pkg::kw_update(keyword_match_flags, run_length, c);
          run_next = dtt_pkg::sat_inc(run_length);
          taken    = 1'b1;
        end else begin
          p_emit    = 1'b1;
          p_kind    = dtt_pkg::kw_kind(keyword_match_flags, run_length);
          mode_next = dtt_pkg::M_IDLE;
        end
      end
      dtt_pkg::M_SYM_START: begin
        if (c == "\"") begin
          mode_next = dtt_pkg::M_Q_SYMBOL;
          esc_next  = 1'b0;
          run_next  = dtt_pkg::sat_inc(run_length);
          taken     = 1'b1;
        end else if (dtt_pkg::is_letter(c)) begin
          mode_next = dtt_pkg::M_SYM_ALPHA;
          run_next  = dtt_pkg::sat_inc(run_length);
          taken     = 1'b1;
        end else begin
          p_emit    = 1'b1;
          p_kind    = dtt_pkg::K_SYMBOL;
          mode_next = dtt_pkg::M_IDLE;
        end
      end
      dtt_pkg::M_SYM_ALPHA: begin
        if (dtt_pkg::is_letter(c)) begin
          run_next = dtt_pkg::sat_inc(run_length);
          taken    = 1'b1;
        end else begin
          p_emit    = 1'b1;
          p_kind    = dtt_pkg::K_SYMBOL;
          mode_next = dtt_pkg::M_IDLE;
        end
      end
      dtt_pkg::M_Q_STRING: begin
        q_step = 1'b1;
        q_kind = dtt_pkg::K_STRING;
      end
      dtt_pkg::M_Q_BINARY: begin
        q_step = 1'b1;
        q_kind = dtt_pkg::K_BINARY;
      end
      dtt_pkg::M_Q_SYMBOL: begin
        q_step = 1'b1;
        q_kind = dtt_pkg::K_SYMBOL;
      end
      default: mode_next = dtt_pkg::M_IDLE;
    endcase

    if (num_step) begin
      after_exp = aft_next;
      aft_next  = 1'b0;
      if ((after_exp && (c == "+" || c == "-")) || dtt_pkg::is_digit(c)) begin
        run_next = dtt_pkg::sat_inc(run_next);
        taken    = 1'b1;
      end else if (c == "." && !dot_next) begin
        dot_next = 1'b1;
        run_next = dtt_pkg::sat_inc(run_next);
        taken    = 1'b1;
      end else if ((c == "e" || c == "E") && !exp_next) begin
        dot_next = 1'b1;
        exp_next = 1'b1;
        aft_next = 1'b1;
        run_next = dtt_pkg::sat_inc(run_next);
        taken    = 1'b1;
      end else begin
        p_emit    = 1'b1;
        p_kind    = (dot_next || exp_next) ? dtt_pkg::K_FLOAT : dtt_pkg::K_INT;
        p_len     = run_next;
        mode_next = dtt_pkg::M_IDLE;
      end
    end

    if (q_step) begin
      if (c == 8'h00) begin
        p_emit    = 1'b1;
        p_kind    = dtt_pkg::K_ERR;
        mode_next = dtt_pkg::M_IDLE;
      end else if (escape_pending) begin
        esc_next = 1'b0;
        run_next = dtt_pkg::sat_inc(run_length);
        taken    = 1'b1;
      end else begin
        run_next = dtt_pkg::sat_inc(run_length);
        taken    = 1'b1;
        if (c == "\"") begin
          p_emit    = 1'b1;
          p_kind    = q_kind;
          p_len     = run_next;
          mode_next = dtt_pkg::M_IDLE;
        end else if (c == "\\") begin
          esc_next = 1'b1;
        end
      end
    end

    // byte not taken: scan it as the start of a new token
    if (!taken) begin
      case (c)
        "{": begin i_emit = 1'b1; i_kind = dtt_pkg::K_LBRACE; end
        "}": begin i_emit = 1'b1; i_kind = dtt_pkg::K_RBRACE; end
        "[": begin i_emit = 1'b1; i_kind = dtt_pkg::K_LBRACK; end
        "]": begin i_emit = 1'b1; i_kind = dtt_pkg::K_RBRACK; end
        "=": begin i_emit = 1'b1; i_kind = dtt_pkg::K_EQUAL; end
        ",": begin i_emit = 1'b1; i_kind = dtt_pkg::K_COMMA; end
        "@": begin i_emit = 1'b1; i_kind = dtt_pkg::K_AT; end
        "$": begin i_emit = 1'b1; i_kind = dtt_pkg::K_DOLLAR; end
        8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: begin
        end
        8'h00: begin
          i_emit = 1'b1;
          i_kind = dtt_pkg::K_EOS;
          i_len  = '0;
        end
        ".", "+", "-", ":", "\"": begin
          start_next = text_offset;
          run_next   = dtt_pkg::LEN_W'(1);
          held_next  = c;
          esc_next   = 1'b0;
          case (c)
            ".":     mode_next = dtt_pkg::M_DOT;
            ":":     mode_next = dtt_pkg::M_SYM_START;
            "\"":    mode_next = dtt_pkg::M_Q_STRING;
            default: mode_next = dtt_pkg::M_SIGN;
          endcase
        end
        default: begin
          if (dtt_pkg::is_digit(c) || dtt_pkg::is_letter(c)) begin
            start_next = text_offset;
            run_next   = dtt_pkg::LEN_W'(1);
            held_next  = c;
            esc_next   = 1'b0;
            if (dtt_pkg::is_digit(c)) begin
              mode_next = dtt_pkg::M_NUMBER;
              dot_next  = 1'b0;
              exp_next  = 1'b0;
              aft_next  = 1'b0;
            end else begin
              mode_next = dtt_pkg::M_ALPHA;
              kw_next   = dtt_pkg::kw_update(3'b111, '0, c);
            end
          end else begin
            i_emit = 1'b1;
          end
        end
      endcase
    end

    if (c == 8'h00) begin
      mode_next   = dtt_pkg::M_IDLE;
      offset_next = '0;
    end else begin
      offset_next = text_offset + OFFSET_BITS'(1);
    end
  end

  always_comb begin
    tok1.kind   = i_kind;
    tok1.offset = 16'(text_offset);
    tok1.length = i_len;
    tok1.last   = 1'b1;
    if (p_emit) begin
      tok0.kind   = p_kind;
      tok0.offset = 16'(start_offset);
      tok0.length = p_len;
      tok0.last   = !i_emit;
    end else begin
      tok0 = tok1;
    end
    tok_cnt = 2'(p_emit) + 2'(i_emit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode              <= dtt_pkg::M_IDLE;
      escape_pending        <= 1'b0;
      seen_dot              <= 1'b0;
      seen_exponent         <= 1'b0;
      after_exponent_letter <= 1'b0;
      start_offset          <= '0;
      run_length            <= '0;
      text_offset           <= '0;
      keyword_match_flags   <= 3'b111;
      held_byte             <= '0;
    end else if (in_fire) begin
      lex_mode              <= mode_next;
      escape_pending        <= esc_next;
      seen_dot              <= dot_next;
      seen_exponent         <= exp_next;
      after_exponent_letter <= aft_next;
      start_offset          <= start_next;
      run_length            <= run_next;
      text_offset           <= offset_next;
      keyword_match_flags   <= kw_next;
      held_byte             <= held_next;
    end
  end

  // token queue
  always_ff @(posedge clk) begin
    if (in_fire && tok_cnt != 2'd0) queue[wr_ptr] <= tok0;
    if (in_fire && tok_cnt == 2'd2) queue[wr_ptr + dtt_pkg::PTR_W'(1)] <= tok1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) wr_ptr <= wr_ptr + dtt_pkg::PTR_W'(tok_cnt);
      if (out_fire) rd_ptr <= rd_ptr + dtt_pkg::PTR_W'(1);
      count <= count + (in_fire ? dtt_pkg::CNT_W'(tok_cnt) : '0)
                     - dtt_pkg::CNT_W'(out_fire);
    end
  end

  assign token_kind   = queue[rd_ptr].kind;
  assign token_offset = queue[rd_ptr].offset;
  assign token_length = queue[rd_ptr].length;
  assign last_of_run  = queue[rd_ptr].last;

endmodule

// ===== sv/dtt_checker.sv =====
// Checker: port-level assertions for the text tokenizer, bound to the top level.
`timescale 1ns / 1ps

module dtt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  token_kind,
  input logic [15:0] token_offset,
  input logic [15:0] token_length,
  input logic        last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(token_kind) && $stable(token_offset) &&
                               $stable(token_length) && $stable(last_of_run))
    else $error("stalled output beat changed");

  a_eos_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == dtt_pkg::K_EOS |-> token_length == 16'd0 && last_of_run)
    else $error("end-of-stream token malformed");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_kind <= dtt_pkg::K_ERR)
    else $error("token kind out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  logic unused_in;
  assign unused_in = ^{in_valid, in_stall, in_byte};

endmodule

bind data_text_tokenizer dtt_checker u_dtt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_byte      (in_byte),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .token_kind   (token_kind),
  .token_offset (token_offset),
  .token_length (token_length),
  .last_of_run  (last_of_run)
);
